// ----- rtl/ibef_pkg.sv -----
// Shared types, constants and codes for the interpolated band edge filter.
package ibef_pkg;

  localparam int GridMaxDef     = 64;
  localparam int GeneSlotsDef   = 256;
  localparam int MatrixGenesDef = 256;

  localparam logic [1:0] ACT_GRID = 2'd0;
  localparam logic [1:0] ACT_LINK = 2'd1;
  localparam logic [1:0] ACT_CORR = 2'd2;
  localparam logic [1:0] ACT_TEST = 2'd3;

  localparam logic [1:0] CFG_DROP_MODE   = 2'd0;
  localparam logic [1:0] CFG_GRID_POINTS = 2'd1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } grid_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_A,
    ST_MAP_B,
    ST_CORR,
    ST_END0,
    ST_ENDN,
    ST_SEARCH,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_START_LO,
    ST_WAIT_LO,
    ST_START_HI,
    ST_WAIT_HI,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/interpolated_band_edge_filter.sv -----
// Top level: stores, lookup and search sequencer, result register.
//
// Channel | Signals                    | Direction
// in      | in_valid_i / in_ready_o    | item in (loads and tests)
// out     | out_valid_o / out_ready_i  | one result per test beat
// cfg     | cfg_we_i                   | register write, no wait
//
// A load beat is written to its store and leaves the input ready. An
// interpolating test beat holds the input through lookup, the end-point reads,
// the search steps, the fetch of both grid entries and the two divider passes.
// A test clamped to an end value skips search and division; an unmapped one also skips the grid reads.
// Reset clears control only; the stores are undefined until written.
// A finished result waits in the output register; a later one waits in the
// last state until that register is free.
module interpolated_band_edge_filter #(
  parameter int GRID_MAX     = ibef_pkg::GridMaxDef,
  parameter int GENE_SLOTS   = ibef_pkg::GeneSlotsDef,
  parameter int MATRIX_GENES = ibef_pkg::MatrixGenesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [1:0]  cfg_index_i,
  input  logic        [6:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [1:0]  action_i,
  input  logic        [7:0]  gene_a_i,
  input  logic        [7:0]  gene_b_i,
  input  logic        [7:0]  matrix_row_i,
  input  logic        [7:0]  matrix_col_i,
  input  logic        [5:0]  grid_slot_i,
  input  logic signed [15:0] grid_x_i,
  input  logic signed [15:0] grid_low_i,
  input  logic signed [15:0] grid_high_i,
  input  logic signed [15:0] corr_value_i,
  input  logic        [8:0]  row_link_i,
  input  logic signed [15:0] edge_score_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               drop_o,
  output logic               unmapped_o,
  output logic signed [15:0] band_low_o,
  output logic signed [15:0] band_high_o
);
  import ibef_pkg::*;

  localparam int GA = $clog2(GRID_MAX);
  localparam int KA = $clog2(GENE_SLOTS);
  localparam int MA = $clog2(MATRIX_GENES);
  localparam int CA = $clog2(MATRIX_GENES * MATRIX_GENES);

  grid_ent_t          grid_mem_q [GRID_MAX];
  logic [8:0]         rm_mem_q   [GENE_SLOTS];
  logic signed [15:0] corr_mem_q [MATRIX_GENES * MATRIX_GENES];

  grid_ent_t          grid_rd_q;
  logic [8:0]         rm_rd_q;
  logic signed [15:0] corr_rd_q;

  logic [GA-1:0] grid_raddr;
  logic [KA-1:0] rm_raddr;
  logic [CA-1:0] corr_raddr, corr_waddr;

  state_e state_q, state_d;
  logic mode_q, cur_mode_q;
  logic [6:0] grid_points_q;
  logic [7:0] gene_b_q;
  logic signed [15:0] score_q, v_q;
  logic [GA-1:0] last_q, lo_q, hi_q, mid_q;
  logic [GA-1:0] lo_n, hi_n, mid_n, last_n;
  logic more_n;
  logic oka_q;
  logic [MA-1:0] ra_q, rb_n;
  logic okb_n, oka_n;
  grid_ent_t e0_q, elo_q, ehi_q;
  logic signed [15:0] res_lo_q, res_hi_q;
  logic res_unm_q;
  logic out_valid_q, drop_q, unm_q;
  logic signed [15:0] band_lo_q, band_hi_q;

  logic in_acc, is_test, start;
  logic div_done;
  logic signed [15:0] div_y;
  logic [15:0] dv, dx;
  logic signed [16:0] dy;
  logic signed [15:0] y0;
  logic res_drop;

  assign in_acc  = in_valid_i && in_ready_o;
  assign is_test = action_i == ACT_TEST;

  always_comb begin
    int unsigned n;
    n = 32'(grid_points_q);
    if (n < 2) n = 2;
    if (n > GRID_MAX) n = GRID_MAX;
    last_n = GA'(n - 1);
  end

  assign oka_n = 32'(gene_a_i) < GENE_SLOTS;
  assign okb_n = (32'(gene_b_q) < GENE_SLOTS) && (rm_rd_q != 9'd0)
                 && (32'(rm_rd_q) <= MATRIX_GENES);
  assign rb_n  = MA'(rm_rd_q - 9'd1);

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (state_q == ST_ENDN) begin
      lo_n = '0;
      hi_n = last_q;
    end else if (grid_rd_q.x <= v_q) begin
      lo_n = mid_q;
    end else begin
      hi_n = mid_q;
    end
    mid_n  = GA'(({1'b0, lo_n} + {1'b0, hi_n}) >> 1);
    more_n = (hi_n - lo_n) > GA'(1);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_acc && is_test) state_d = ST_MAP_A;
      ST_MAP_A:    state_d = ST_MAP_B;
      ST_MAP_B:    state_d = (oka_q && okb_n) ? ST_CORR : ST_DONE;
      ST_CORR:     state_d = ST_END0;
      ST_END0:     state_d = ST_ENDN;
      ST_ENDN: begin
        if (v_q <= e0_q.x || v_q >= grid_rd_q.x) state_d = ST_DONE;
        else if (more_n) state_d = ST_SEARCH;
        else state_d = ST_FETCH_LO;
      end
      ST_SEARCH:   if (!more_n) state_d = ST_FETCH_LO;
      ST_FETCH_LO: state_d = ST_FETCH_HI;
      ST_FETCH_HI: state_d = ST_START_LO;
      ST_START_LO: state_d = ST_WAIT_LO;
      ST_WAIT_LO:  if (div_done) state_d = ST_START_HI;
      ST_START_HI: state_d = ST_WAIT_HI;
      ST_WAIT_HI:  if (div_done) state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    start      = 1'b0;
    rm_raddr   = KA'(gene_a_i);
    grid_raddr = '0;
    corr_raddr = CA'(ra_q) * CA'(MATRIX_GENES) + CA'(rb_n);
    unique case (state_q)
      ST_IDLE:     in_ready_o = 1'b1;
      ST_MAP_A:    rm_raddr = KA'(gene_b_q);
      ST_END0:     grid_raddr = last_q;
      ST_ENDN:     grid_raddr = more_n ? mid_n : lo_n;
      ST_SEARCH:   grid_raddr = more_n ? mid_n : lo_n;
      ST_FETCH_LO: grid_raddr = hi_q;
      ST_START_LO: start = 1'b1;
      ST_START_HI: start = 1'b1;
      default:     grid_raddr = '0;
    endcase
  end

  assign dv = 16'(v_q - elo_q.x);
  assign dx = 16'(ehi_q.x - elo_q.x);
  assign dy = (state_q == ST_START_LO) ? 17'(ehi_q.lo) - 17'(elo_q.lo)
                                       : 17'(ehi_q.hi) - 17'(elo_q.hi);
  assign y0 = (state_q == ST_START_LO) ? elo_q.lo : elo_q.hi;

  ibef_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .dv_i   (dv),
    .dy_i   (dy),
    .dx_i   (dx),
    .y0_i   (y0),
    .done_o (div_done),
    .y_o    (div_y)
  );

  assign corr_waddr = CA'(matrix_row_i) * CA'(MATRIX_GENES) + CA'(matrix_col_i);

  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_GRID && 32'(grid_slot_i) < GRID_MAX) begin
      grid_mem_q[GA'(grid_slot_i)] <= '{x: grid_x_i, lo: grid_low_i, hi: grid_high_i};
    end
    grid_rd_q <= grid_mem_q[grid_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_LINK && oka_n) begin
      rm_mem_q[KA'(gene_a_i)] <= row_link_i;
    end
    rm_rd_q <= rm_mem_q[rm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ACT_CORR && 32'(matrix_row_i) < MATRIX_GENES
        && 32'(matrix_col_i) < MATRIX_GENES) begin
      corr_mem_q[corr_waddr] <= corr_value_i;
    end
    corr_rd_q <= corr_mem_q[corr_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= 1'b0;
      grid_points_q <= 7'd2;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DROP_MODE:   mode_q <= cfg_data_i[0];
          CFG_GRID_POINTS: grid_points_q <= cfg_data_i;
          default:         mode_q <= mode_q;
        endcase
      end
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_drop = cur_mode_q ? (score_q < res_lo_q || score_q > res_hi_q)
                               : (score_q <= res_hi_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        gene_b_q   <= gene_b_i;
        score_q    <= edge_score_i;
        cur_mode_q <= mode_q;
        last_q     <= last_n;
        oka_q      <= oka_n;
      end
      ST_MAP_A: begin
        oka_q <= oka_q && rm_rd_q != 9'd0 && 32'(rm_rd_q) <= MATRIX_GENES;
        ra_q  <= MA'(rm_rd_q - 9'd1);
      end
      ST_MAP_B: begin
        res_unm_q <= !(oka_q && okb_n);
        res_lo_q  <= '0;
        res_hi_q  <= '0;
      end
      ST_CORR:  v_q  <= corr_rd_q;
      ST_END0:  e0_q <= grid_rd_q;
      ST_ENDN: begin
        if (v_q <= e0_q.x) begin
          res_lo_q <= e0_q.lo;
          res_hi_q <= e0_q.hi;
        end else if (v_q >= grid_rd_q.x) begin
          res_lo_q <= grid_rd_q.lo;
          res_hi_q <= grid_rd_q.hi;
        end
        lo_q  <= lo_n;
        hi_q  <= hi_n;
        mid_q <= mid_n;
      end
      ST_SEARCH: begin
        lo_q  <= lo_n;
        hi_q  <= hi_n;
        mid_q <= mid_n;
      end
      ST_FETCH_LO: elo_q <= grid_rd_q;
      ST_FETCH_HI: ehi_q <= grid_rd_q;
      ST_WAIT_LO:  if (div_done) res_lo_q <= div_y;
      ST_WAIT_HI:  if (div_done) res_hi_q <= div_y;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          drop_q    <= !res_unm_q && res_drop;
          unm_q     <= res_unm_q;
          band_lo_q <= res_lo_q;
          band_hi_q <= res_hi_q;
        end
      end
      default: v_q <= v_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign drop_o      = drop_q;
  assign unmapped_o  = unm_q;
  assign band_low_o  = band_lo_q;
  assign band_high_o = band_hi_q;

endmodule

// ----- rtl/ibef_interp.sv -----
// Sequential interpolation unit: one multiply, then a two-bit-per-cycle divider.
module ibef_interp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic        [15:0] dv_i,
  input  logic signed [16:0] dy_i,
  input  logic        [15:0] dx_i,
  input  logic signed [15:0] y0_i,
  output logic               done_o,
  output logic signed [15:0] y_o
);
  import ibef_pkg::*;

  logic        busy_q, mul_q, done_q;
  logic [2:0]  cnt_q;
  logic        neg_q;
  logic [15:0] dv_q, dmag_q, dx_q;
  logic signed [15:0] y0_q, y_q;
  logic [16:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [31:0] prod;
  logic [16:0] dy_abs;
  logic signed [17:0] sum;

  assign dy_abs = dy_i[16] ? 17'(-dy_i) : 17'(dy_i);
  assign prod   = dv_q * dmag_q;

  always_comb begin
    logic [16:0] r;
    logic [15:0] q;
    r = rem_q;
    q = quo_q;
    for (int k = 0; k < 2; k++) begin
      r = {r[15:0], q[15]};
      q = {q[14:0], 1'b0};
      if (r >= {1'b0, dx_q}) begin
        r = r - {1'b0, dx_q};
        q[0] = 1'b1;
      end
    end
    rem_d = r;
    quo_d = q;
  end

  assign sum = 18'(y0_q) + (neg_q ? -18'(quo_d) : 18'(quo_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        mul_q  <= 1'b1;
      end else if (mul_q) begin
        mul_q <= 1'b0;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q   <= dv_i;
      dmag_q <= dy_abs[15:0];
      neg_q  <= dy_i[16];
      dx_q   <= dx_i;
      y0_q   <= y0_i;
    end else if (mul_q) begin
      rem_q <= {1'b0, prod[31:16]};
      quo_q <= prod[15:0];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == 3'd7) begin
        y_q <= sum[15:0];
      end
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

// ----- rtl/ibef_check.sv -----
// Port-level assertions for the interpolated band edge filter, bound to the top level.
module ibef_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic        [1:0]  action_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               drop_o,
  input logic               unmapped_o,
  input logic signed [15:0] band_low_o,
  input logic signed [15:0] band_high_o
);
  import ibef_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(band_low_o)
      && $stable(band_high_o) && $stable(drop_o) && $stable(unmapped_o))
    else $error("result beat changed while stalled");

  a_unmapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unmapped_o |-> !drop_o && band_low_o == 16'sd0
      && band_high_o == 16'sd0)
    else $error("unmapped result carries a band or a drop");

  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_TEST |=> !in_ready_o)
    else $error("input taken while a test beat is in work");

  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result beat appeared without a test in work");

endmodule

bind interpolated_band_edge_filter ibef_check u_ibef_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .action_i   (action_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .drop_o     (drop_o),
  .unmapped_o (unmapped_o),
  .band_low_o (band_low_o),
  .band_high_o(band_high_o)
);
